[rtl/core/peer_view_table_assert.svh]
`ifndef PEER_VIEW_TABLE_ASSERT_SVH
`define PEER_VIEW_TABLE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PVT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("peer_view_table port check failed");

// consequent checked in the cycle after the antecedent
`define PVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("peer_view_table port check failed");

`endif

[rtl/core/pvt_pkg.sv]
package pvt_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEXT,
        ST_SEARCH,
        ST_COMPACT,
        ST_MODW,
        ST_VREAD,
        ST_APPEND,
        ST_EMIT
    } t_state;

    // position within the operation
    typedef enum logic [4:0] {
        PH_START,
        PH_A_SRCHP,
        PH_A_CMPP,
        PH_A_SRCHA,
        PH_A_MOD,
        PH_A_VRD,
        PH_A_CMPA,
        PH_I_SRCHA,
        PH_I_SRCHP,
        PH_I_MOD,
        PH_I_VRD,
        PH_I_CMPP,
        PH_I_APP,
        PH_A_APP,
        PH_D_SRCH,
        PH_D_CMP,
        PH_F_SRCH
    } t_phase;

    // opcodes
    localparam logic [3:0] OP_ADD_ACT  = 4'd0;
    localparam logic [3:0] OP_ADD_PAS  = 4'd1;
    localparam logic [3:0] OP_DROP_AP  = 4'd2;
    localparam logic [3:0] OP_DROP_AS  = 4'd3;
    localparam logic [3:0] OP_DROP_PS  = 4'd4;
    localparam logic [3:0] OP_FIND_AP  = 4'd5;
    localparam logic [3:0] OP_FIND_AS  = 4'd6;
    localparam logic [3:0] OP_FIND_PP  = 4'd7;
    localparam logic [3:0] OP_FIND_PS  = 4'd8;

    // result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_NOTICE = 2'd1;
    localparam logic [1:0] KIND_CLOSE  = 2'd2;

    // register indexes
    localparam logic [1:0] CFG_ACT_CAP = 2'd0;
    localparam logic [1:0] CFG_PAS_CAP = 2'd1;
    localparam logic [1:0] CFG_SEED    = 2'd2;

    localparam logic [15:0] LFSR_TAPS  = 16'hB400;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] peer;
        logic [15:0] sock;
    } t_event;

    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
    } t_mod_req;

    // one galois step, never zero
    function automatic logic [15:0] lfsr_next(input logic [15:0] v);
        logic [15:0] s;
        s = v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
        return (s == 16'd0) ? 16'd1 : s;
    endfunction

endpackage

[rtl/core/pvt_mod.sv]
module pvt_mod #(
    parameter int DW = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pvt_pkg::t_mod_req i_req,
    input  logic [DW-1:0]     i_divisor,
    output logic              o_done,
    output logic [DW-1:0]     o_rem
);
    import pvt_pkg::*;

    logic          r_busy;
    logic          r_done;
    logic [3:0]    r_cnt;
    logic [15:0]   r_dvd;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [DW:0]   w_trial;

    // one quotient bit per cycle, restoring
    assign w_trial = {r_rem, r_dvd[15]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd15;
                r_dvd  <= i_req.dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                if (w_trial >= {1'b0, r_div}) begin
                    r_rem <= DW'(w_trial - {1'b0, r_div});
                end else begin
                    r_rem <= w_trial[DW-1:0];
                end
                r_dvd <= {r_dvd[14:0], 1'b0};
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[rtl/core/peer_view_table.sv]
// peer_view_table: active and passive peer tables kept in two on-chip memories.
// Request channel: i_in_valid with o_in_stall; a request carries an opcode,
// peer id, socket handle and socket-valid mark. Result channel: o_out_valid
// with i_out_stall; each request yields up to two events (disconnect notice,
// socket close) followed by one status item with o_last set.
// Configuration: i_cfg_valid/o_cfg_ready (always ready) writes the active and
// passive capacities and the eviction seed; write only while idle.
// Sequencing: one request at a time; each table search or compaction walks the
// memory one entry per cycle, after a sequencing state; each random eviction
// adds a bit-serial modulo and a read of the victim, and each result is
// loaded into the output register in turn.
// Reset (synchronous, active low) empties both tables, loads capacities 5
// and 30 and seeds the LFSR with 1; no memory sweep is needed.
// A stalled result holds; o_in_stall stays high until the last result of the
// request has been loaded into the output register.
module peer_view_table #(
    parameter int ACTIVE_DEPTH  = 8,
    parameter int PASSIVE_DEPTH = 32,
    parameter int ID_BITS       = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_opcode,
    input  logic [15:0] i_peer_id,
    input  logic [15:0] i_socket_handle,
    input  logic        i_has_socket,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_target_peer,
    output logic [15:0] o_target_socket,
    output logic        o_found,
    output logic [4:0]  o_position,
    output logic [3:0]  o_active_count,
    output logic [5:0]  o_passive_count,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import pvt_pkg::*;

    localparam int AAW = (ACTIVE_DEPTH > 1) ? $clog2(ACTIVE_DEPTH) : 1;
    localparam int PAW = (PASSIVE_DEPTH > 1) ? $clog2(PASSIVE_DEPTH) : 1;
    localparam int ACW = $clog2(ACTIVE_DEPTH + 1);
    localparam int PCW = $clog2(PASSIVE_DEPTH + 1);
    localparam int IW  = (PCW > ACW) ? PCW : ACW;
    localparam int EW  = ID_BITS + 17;

    // entry layout: valid, socket, peer
    function automatic logic [15:0] ent_peer16(input logic [EW-1:0] e);
        logic [ID_BITS+15:0] x;
        x = {16'd0, e[ID_BITS-1:0]};
        return x[15:0];
    endfunction

    function automatic logic [15:0] ent_sock(input logic [EW-1:0] e);
        return e[EW-1] ? e[ID_BITS+15:ID_BITS] : 16'd0;
    endfunction

    function automatic t_event mk_event(input logic [1:0] k, input logic [EW-1:0] e);
        t_event ev;
        ev.kind = k;
        ev.peer = ent_peer16(e);
        ev.sock = ent_sock(e);
        return ev;
    endfunction

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    logic [3:0]          r_cap_a;
    logic [5:0]          r_cap_p;
    logic [15:0]         r_lfsr;
    logic [ACW-1:0]      r_au;
    logic [PCW-1:0]      r_pu;
    logic [3:0]          r_op;
    logic [EW-1:0]       r_key;
    logic [EW-1:0]       r_ins;
    logic [EW-1:0]       r_hent;
    logic [IW-1:0]       r_hidx;
    logic                r_hit;
    logic                r_found;
    logic [IW-1:0]       r_pos;
    logic                r_shown;
    logic                r_tsel;
    logic [ID_BITS-1:0]  r_spe;
    logic [15:0]         r_sso;
    logic                r_sbs;
    logic [IW-1:0]       r_i;
    logic [IW-1:0]       r_pidx;
    logic                r_pend;
    logic                r_sub;
    t_event              r_ev [2];
    logic [1:0]          r_nev;
    logic [1:0]          r_e;

    logic                r_ov;
    logic [1:0]          r_kind;
    logic [15:0]         r_tpeer;
    logic [15:0]         r_tsock;
    logic                r_ofound;
    logic [4:0]          r_opos;
    logic [3:0]          r_oac;
    logic [5:0]          r_opc;
    logic                r_olast;

    logic [EW-1:0]       mem_a [ACTIVE_DEPTH];
    logic [EW-1:0]       mem_p [PASSIVE_DEPTH];
    logic [EW-1:0]       r_rd_a;
    logic [EW-1:0]       r_rd_p;

    logic                in_acc;
    logic [EW-1:0]       in_ent;
    logic [EW-1:0]       rdata;
    logic [IW-1:0]       s_n;
    logic                s_match, s_hit_now, s_more, srch_done;
    logic                c_more, cmp_done;
    logic                full_a, full_p, app_ok;
    logic                l_tsel, l_sbs;
    logic [ID_BITS-1:0]  l_spe;
    logic [15:0]         l_sso;
    logic [IW-1:0]       rd_idx, wr_idx;
    logic                wr_en;
    logic [EW-1:0]       wr_data;
    logic                slot_free, emit_status;
    t_mod_req            mod_req;
    logic                mod_done;
    logic [IW-1:0]       mod_rem;
    logic [ID_BITS+15:0] peer_ext;
    logic [IW+4:0]       pos_ext;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign peer_ext = {{ID_BITS{1'b0}}, i_peer_id};
    assign in_ent   = {i_has_socket, i_socket_handle, peer_ext[ID_BITS-1:0]};

    // current table view
    assign rdata     = r_tsel ? r_rd_p : r_rd_a;
    assign s_n       = r_tsel ? IW'(r_pu) : IW'(r_au);
    assign s_match   = r_sbs ? (rdata[EW-1] && (rdata[ID_BITS+15:ID_BITS] == r_sso))
                             : (rdata[ID_BITS-1:0] == r_spe);
    assign s_hit_now = r_pend && s_match;
    assign s_more    = r_i < s_n;
    assign srch_done = s_hit_now || !s_more;
    assign c_more    = ({1'b0, r_i} + {{IW{1'b0}}, 1'b1}) < {1'b0, s_n};
    assign cmp_done  = !c_more && !r_pend;

    // fullness against saturated capacity
    assign full_a = ((r_cap_a == 4'd0) ? (r_au != '0) : (8'(r_au) >= 8'(r_cap_a)))
                    || (r_au == ACW'(ACTIVE_DEPTH));
    assign full_p = ((r_cap_p == 6'd0) ? (r_pu != '0) : (8'(r_pu) >= 8'(r_cap_p)))
                    || (r_pu == PCW'(PASSIVE_DEPTH));
    assign app_ok = r_tsel ? (r_pu < PCW'(PASSIVE_DEPTH)) : (r_au < ACW'(ACTIVE_DEPTH));

    assign slot_free   = !r_ov || !i_out_stall;
    assign emit_status = (r_e >= r_nev);

    // next state
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        l_tsel  = r_tsel;
        l_spe   = r_spe;
        l_sso   = r_sso;
        l_sbs   = r_sbs;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_NEXT;
                    n_phase = PH_START;
                end
            end
            ST_NEXT: begin
                unique case (r_phase)
                    PH_START: begin
                        n_state = ST_SEARCH;
                        l_spe   = r_key[ID_BITS-1:0];
                        l_sso   = r_key[ID_BITS+15:ID_BITS];
                        unique case (r_op)
                            OP_ADD_ACT: begin
                                l_tsel = 1'b1; l_sbs = 1'b0; n_phase = PH_A_SRCHP;
                            end
                            OP_ADD_PAS: begin
                                l_tsel = 1'b0; l_sbs = 1'b0; n_phase = PH_I_SRCHA;
                            end
                            OP_DROP_AP: begin
                                l_tsel = 1'b0; l_sbs = 1'b0; n_phase = PH_D_SRCH;
                            end
                            OP_DROP_AS: begin
                                l_tsel = 1'b0; l_sbs = 1'b1; n_phase = PH_D_SRCH;
                            end
                            OP_DROP_PS: begin
                                l_tsel = 1'b1; l_sbs = 1'b1; n_phase = PH_D_SRCH;
                            end
                            OP_FIND_AP: begin
                                l_tsel = 1'b0; l_sbs = 1'b0; n_phase = PH_F_SRCH;
                            end
                            OP_FIND_AS: begin
                                l_tsel = 1'b0; l_sbs = 1'b1; n_phase = PH_F_SRCH;
                            end
                            OP_FIND_PP: begin
                                l_tsel = 1'b1; l_sbs = 1'b0; n_phase = PH_F_SRCH;
                            end
                            OP_FIND_PS: begin
                                l_tsel = 1'b1; l_sbs = 1'b1; n_phase = PH_F_SRCH;
                            end
                            default: begin
                                n_state = ST_EMIT;
                            end
                        endcase
                    end
                    PH_A_SRCHP: begin
                        if (r_hit) begin
                            n_state = ST_COMPACT; l_tsel = 1'b1; n_phase = PH_A_CMPP;
                        end else begin
                            n_state = ST_SEARCH; l_tsel = 1'b0; n_phase = PH_A_SRCHA;
                        end
                    end
                    PH_A_CMPP: begin
                        n_state = ST_SEARCH; l_tsel = 1'b0; n_phase = PH_A_SRCHA;
                    end
                    PH_A_SRCHA: begin
                        if (r_hit) begin
                            n_state = ST_EMIT;
                        end else if (full_a) begin
                            n_state = ST_MODW; l_tsel = 1'b0; n_phase = PH_A_MOD;
                        end else begin
                            n_state = ST_APPEND; l_tsel = 1'b0; n_phase = PH_A_APP;
                        end
                    end
                    PH_A_MOD: begin
                        n_state = ST_VREAD; l_tsel = 1'b0; n_phase = PH_A_VRD;
                    end
                    PH_A_VRD: begin
                        n_state = ST_COMPACT; l_tsel = 1'b0; n_phase = PH_A_CMPA;
                    end
                    PH_A_CMPA: begin
                        n_state = ST_SEARCH; l_tsel = 1'b0; l_sbs = 1'b0;
                        l_spe   = r_ins[ID_BITS-1:0]; n_phase = PH_I_SRCHA;
                    end
                    PH_I_SRCHA: begin
                        if (r_hit) begin
                            if (r_op == OP_ADD_ACT) begin
                                n_state = ST_APPEND; l_tsel = 1'b0; n_phase = PH_A_APP;
                            end else begin
                                n_state = ST_EMIT;
                            end
                        end else begin
                            n_state = ST_SEARCH; l_tsel = 1'b1; n_phase = PH_I_SRCHP;
                        end
                    end
                    PH_I_SRCHP: begin
                        if (r_hit) begin
                            if (r_op == OP_ADD_ACT) begin
                                n_state = ST_APPEND; l_tsel = 1'b0; n_phase = PH_A_APP;
                            end else begin
                                n_state = ST_EMIT;
                            end
                        end else if (full_p) begin
                            n_state = ST_MODW; l_tsel = 1'b1; n_phase = PH_I_MOD;
                        end else begin
                            n_state = ST_APPEND; l_tsel = 1'b1; n_phase = PH_I_APP;
                        end
                    end
                    PH_I_MOD: begin
                        n_state = ST_VREAD; l_tsel = 1'b1; n_phase = PH_I_VRD;
                    end
                    PH_I_VRD: begin
                        n_state = ST_COMPACT; l_tsel = 1'b1; n_phase = PH_I_CMPP;
                    end
                    PH_I_CMPP: begin
                        n_state = ST_APPEND; l_tsel = 1'b1; n_phase = PH_I_APP;
                    end
                    PH_I_APP: begin
                        if (r_op == OP_ADD_ACT) begin
                            n_state = ST_APPEND; l_tsel = 1'b0; n_phase = PH_A_APP;
                        end else begin
                            n_state = ST_EMIT;
                        end
                    end
                    PH_A_APP: begin
                        n_state = ST_EMIT;
                    end
                    PH_D_SRCH: begin
                        if (r_hit) begin
                            n_state = ST_COMPACT; n_phase = PH_D_CMP;
                        end else begin
                            n_state = ST_EMIT;
                        end
                    end
                    PH_D_CMP: begin
                        n_state = ST_EMIT;
                    end
                    PH_F_SRCH: begin
                        n_state = ST_EMIT;
                    end
                    default: begin
                        n_state = ST_EMIT;
                    end
                endcase
            end
            ST_SEARCH: begin
                if (srch_done) n_state = ST_NEXT;
            end
            ST_COMPACT: begin
                if (cmp_done) n_state = ST_NEXT;
            end
            ST_MODW: begin
                if (mod_done) n_state = ST_NEXT;
            end
            ST_VREAD: begin
                if (r_sub) n_state = ST_NEXT;
            end
            ST_APPEND: begin
                n_state = ST_NEXT;
            end
            ST_EMIT: begin
                if (slot_free && emit_status) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // memory and handshake controls
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        rd_idx     = r_i;
        wr_en      = 1'b0;
        wr_idx     = r_pidx;
        wr_data    = rdata;
        unique case (r_state)
            ST_COMPACT: begin
                rd_idx = r_i + {{(IW-1){1'b0}}, 1'b1};
                wr_en  = r_pend;
            end
            ST_VREAD: begin
                rd_idx = r_hidx;
            end
            ST_APPEND: begin
                wr_en   = app_ok;
                wr_idx  = s_n;
                wr_data = r_tsel ? r_ins : r_key;
            end
            default: begin
                rd_idx = r_i;
            end
        endcase
    end

    assign mod_req.start    = (r_state == ST_NEXT) && (n_state == ST_MODW);
    assign mod_req.dividend = lfsr_next(r_lfsr);

    pvt_mod #(
        .DW (IW)
    ) u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mod_req),
        .i_divisor (l_tsel ? IW'(r_pu) : IW'(r_au)),
        .o_done    (mod_done),
        .o_rem     (mod_rem)
    );

    // table memories, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en && !r_tsel) mem_a[wr_idx[AAW-1:0]] <= wr_data;
        r_rd_a <= mem_a[rd_idx[AAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && r_tsel) mem_p[wr_idx[PAW-1:0]] <= wr_data;
        r_rd_p <= mem_p[rd_idx[PAW-1:0]];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_START;
            r_cap_a <= 4'd5;
            r_cap_p <= 6'd30;
            r_lfsr  <= 16'd1;
            r_au    <= '0;
            r_pu    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ACT_CAP: r_cap_a <= i_cfg_data[3:0];
                    CFG_PAS_CAP: r_cap_p <= i_cfg_data[5:0];
                    CFG_SEED:    r_lfsr  <= (i_cfg_data == 16'd0) ? 16'd1 : i_cfg_data;
                    default: ;
                endcase
            end
            if (mod_req.start) r_lfsr <= mod_req.dividend;
            if (r_state == ST_COMPACT && cmp_done) begin
                if (r_tsel) r_pu <= r_pu - PCW'(1);
                else        r_au <= r_au - ACW'(1);
            end
            if (r_state == ST_APPEND && app_ok) begin
                if (r_tsel) r_pu <= r_pu + PCW'(1);
                else        r_au <= r_au + ACW'(1);
            end
            if (!i_out_stall) r_ov <= 1'b0;
            if (r_state == ST_EMIT && slot_free) r_ov <= 1'b1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_op    <= i_opcode;
                    r_key   <= in_ent;
                    r_ins   <= in_ent;
                    r_found <= 1'b0;
                    r_pos   <= '0;
                    r_shown <= 1'b0;
                    r_nev   <= 2'd0;
                end
            end
            ST_NEXT: begin
                r_tsel <= l_tsel;
                r_spe  <= l_spe;
                r_sso  <= l_sso;
                r_sbs  <= l_sbs;
                r_i    <= (n_state == ST_COMPACT) ? r_hidx : '0;
                r_pend <= 1'b0;
                r_sub  <= 1'b0;
                r_e    <= 2'd0;
                if (n_state == ST_SEARCH) r_hit <= 1'b0;
                case (r_phase)
                    PH_A_SRCHA: begin
                        if (r_hit) begin
                            r_found <= 1'b1;
                            r_pos   <= r_hidx;
                        end
                    end
                    PH_I_SRCHA, PH_I_SRCHP: begin
                        if (r_hit && r_op == OP_ADD_PAS) begin
                            r_found <= 1'b1;
                            r_pos   <= r_hidx;
                        end
                    end
                    PH_A_VRD: begin
                        r_ins            <= r_hent;
                        r_ev[r_nev[0]]   <= mk_event(KIND_NOTICE, r_hent);
                        r_nev            <= r_nev + 2'd1;
                    end
                    PH_I_VRD: begin
                        if (r_hent[EW-1]) begin
                            r_ev[r_nev[0]] <= mk_event(KIND_CLOSE, r_hent);
                            r_nev          <= r_nev + 2'd1;
                        end
                    end
                    PH_D_SRCH: begin
                        if (r_hit) begin
                            r_found <= 1'b1;
                            r_pos   <= r_hidx;
                            if (r_op == OP_DROP_PS) begin
                                r_ev[r_nev[0]] <= mk_event(KIND_CLOSE, r_hent);
                                r_nev          <= r_nev + 2'd1;
                            end
                        end
                    end
                    PH_F_SRCH: begin
                        if (r_hit) begin
                            r_found <= 1'b1;
                            r_pos   <= r_hidx;
                            r_shown <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_SEARCH: begin
                if (s_hit_now) begin
                    r_hit  <= 1'b1;
                    r_hidx <= r_pidx;
                    r_hent <= rdata;
                end else if (s_more) begin
                    r_pend <= 1'b1;
                    r_pidx <= r_i;
                    r_i    <= r_i + {{(IW-1){1'b0}}, 1'b1};
                end
            end
            ST_COMPACT: begin
                r_pend <= c_more;
                if (c_more) begin
                    r_pidx <= r_i;
                    r_i    <= r_i + {{(IW-1){1'b0}}, 1'b1};
                end
            end
            ST_MODW: begin
                if (mod_done) r_hidx <= mod_rem;
            end
            ST_VREAD: begin
                r_sub <= 1'b1;
                if (r_sub) r_hent <= rdata;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    r_oac <= 4'(r_au);
                    r_opc <= 6'(r_pu);
                    if (!emit_status) begin
                        r_kind   <= r_ev[r_e[0]].kind;
                        r_tpeer  <= r_ev[r_e[0]].peer;
                        r_tsock  <= r_ev[r_e[0]].sock;
                        r_ofound <= 1'b0;
                        r_opos   <= 5'd0;
                        r_olast  <= 1'b0;
                        r_e      <= r_e + 2'd1;
                    end else begin
                        r_kind   <= KIND_STATUS;
                        r_tpeer  <= r_shown ? ent_peer16(r_hent) : 16'd0;
                        r_tsock  <= r_shown ? ent_sock(r_hent) : 16'd0;
                        r_ofound <= r_found;
                        r_opos   <= pos_ext[4:0];
                        r_olast  <= 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign pos_ext = {5'd0, r_pos};

    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_ov;
    assign o_kind          = r_kind;
    assign o_target_peer   = r_tpeer;
    assign o_target_socket = r_tsock;
    assign o_found         = r_ofound;
    assign o_position      = r_opos;
    assign o_active_count  = r_oac;
    assign o_passive_count = r_opc;
    assign o_last          = r_olast;

endmodule

[rtl/core/pvt_checker.sv]
`include "peer_view_table_assert.svh"

module pvt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_kind,
    input logic [15:0] o_target_peer,
    input logic        o_last
);
    import pvt_pkg::*;

    // a stalled result holds
    `PVT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_target_peer) && $stable(o_last))

    // only the status closes a request's results
    `PVT_ASSERT_NOW(a_last_is_status, i_clk, i_rst_n, o_out_valid, o_last == (o_kind == KIND_STATUS))

    // no new request while an event of the current one is shown
    `PVT_ASSERT_NOW(a_busy_mid_burst, i_clk, i_rst_n, o_out_valid && !o_last, o_in_stall)

    // a taken request blocks the channel
    `PVT_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

endmodule

bind peer_view_table pvt_checker u_pvt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_kind        (o_kind),
    .o_target_peer (o_target_peer),
    .o_last        (o_last)
);

[sim/tb_peer_view_table.sv]
module tb_peer_view_table;
    import pvt_pkg::*;

    localparam int ACT_DEPTH   = 8;
    localparam int PAS_DEPTH   = 32;
    localparam int HALF_PERIOD = 4;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 200;
    localparam logic [3:0] OP_UNKNOWN = 4'd15;

    // one result item, field order as on the ports
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] peer;
        logic [15:0] sock;
        logic        found;
        logic [4:0]  pos;
        logic [3:0]  act_n;
        logic [5:0]  pas_n;
        logic        last;
    } t_result;

    typedef struct {
        logic [15:0] peer;
        logic [15:0] sock;
        logic        ok;
    } t_peer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [3:0]  i_opcode;
    logic [15:0] i_peer_id;
    logic [15:0] i_socket_handle;
    logic        i_has_socket;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_kind;
    logic [15:0] o_target_peer;
    logic [15:0] o_target_socket;
    logic        o_found;
    logic [4:0]  o_position;
    logic [3:0]  o_active_count;
    logic [5:0]  o_passive_count;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    // table mirror
    t_peer       act_tab [ACT_DEPTH];
    t_peer       pas_tab [PAS_DEPTH];
    int          act_n;
    int          pas_n;
    int          act_cap;
    int          pas_cap;
    logic [15:0] evict_lfsr;

    t_result     request_events[$];
    t_result     expected_results[$];

    int          mismatches = 0;
    int          cycles = 0;
    int          send_idle_pct;
    int          stall_pct;

    peer_view_table uut (.*);

    // clock
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic int sat_cap(int c, int depth);
        return (c < 1) ? 1 : ((c > depth) ? depth : c);
    endfunction

    // advance eviction lfsr and pick a victim index
    function automatic int evict_pick(int n);
        logic [15:0] v;
        v = evict_lfsr[0] ? ((evict_lfsr >> 1) ^ LFSR_TAPS) : (evict_lfsr >> 1);
        if (v == 16'd0) v = 16'd1;
        evict_lfsr = v;
        return (n != 0) ? int'(v % n) : 0;
    endfunction

    function automatic int act_by_peer(logic [15:0] id);
        for (int i = 0; i < act_n; i++) if (act_tab[i].peer == id) return i;
        return -1;
    endfunction

    function automatic int pas_by_peer(logic [15:0] id);
        for (int i = 0; i < pas_n; i++) if (pas_tab[i].peer == id) return i;
        return -1;
    endfunction

    function automatic int act_by_sock(logic [15:0] s);
        for (int i = 0; i < act_n; i++) if (act_tab[i].ok && act_tab[i].sock == s) return i;
        return -1;
    endfunction

    function automatic int pas_by_sock(logic [15:0] s);
        for (int i = 0; i < pas_n; i++) if (pas_tab[i].ok && pas_tab[i].sock == s) return i;
        return -1;
    endfunction

    function automatic void act_remove(int idx);
        for (int k = idx; k < act_n - 1; k++) act_tab[k] = act_tab[k + 1];
        act_n--;
    endfunction

    function automatic void pas_remove(int idx);
        for (int k = idx; k < pas_n - 1; k++) pas_tab[k] = pas_tab[k + 1];
        pas_n--;
    endfunction

    function automatic void note_event(logic [1:0] kind, t_peer e);
        t_result r;
        r = '0;
        r.kind = kind;
        r.peer = e.peer;
        r.sock = e.ok ? e.sock : 16'd0;
        request_events = {request_events, r};
    endfunction

    // passive insert; index of an existing entry in either table, else -1
    function automatic int pas_insert(t_peer e);
        int idx;
        t_peer gone;
        idx = act_by_peer(e.peer);
        if (idx >= 0) return idx;
        idx = pas_by_peer(e.peer);
        if (idx >= 0) return idx;
        if (pas_n >= sat_cap(pas_cap, PAS_DEPTH)) begin
            idx = evict_pick(pas_n);
            gone = pas_tab[idx];
            pas_remove(idx);
            if (gone.ok) note_event(KIND_CLOSE, gone);
        end
        if (pas_n < PAS_DEPTH) begin
            pas_tab[pas_n] = e;
            pas_n++;
        end
        return -1;
    endfunction

    // expected results of one request, appended to the store
    function automatic void predict_request(logic [3:0] op, logic [15:0] peer,
                                            logic [15:0] sock, logic has);
        t_peer   ne;
        t_peer   gone;
        t_peer   hit;
        t_result st;
        int      idx;
        int      v;
        ne.peer = peer;
        ne.sock = sock;
        ne.ok   = has;
        hit     = '{16'd0, 16'd0, 1'b0};
        st      = '0;
        request_events.delete();
        case (op)
            OP_ADD_ACT: begin
                idx = pas_by_peer(peer);
                if (idx >= 0) pas_remove(idx);
                idx = act_by_peer(peer);
                if (idx >= 0) begin
                    st.found = 1'b1;
                    st.pos   = idx[4:0];
                end else begin
                    if (act_n >= sat_cap(act_cap, ACT_DEPTH)) begin
                        v    = evict_pick(act_n);
                        gone = act_tab[v];
                        note_event(KIND_NOTICE, gone);
                        act_remove(v);
                        void'(pas_insert(gone));
                    end
                    if (act_n < ACT_DEPTH) begin
                        act_tab[act_n] = ne;
                        act_n++;
                    end
                end
            end
            OP_ADD_PAS: begin
                idx = pas_insert(ne);
                if (idx >= 0) begin
                    st.found = 1'b1;
                    st.pos   = idx[4:0];
                end
            end
            OP_DROP_AP, OP_DROP_AS: begin
                idx = (op == OP_DROP_AP) ? act_by_peer(peer) : act_by_sock(sock);
                if (idx >= 0) begin
                    st.found = 1'b1;
                    st.pos   = idx[4:0];
                    act_remove(idx);
                end
            end
            OP_DROP_PS: begin
                idx = pas_by_sock(sock);
                if (idx >= 0) begin
                    hit      = pas_tab[idx];
                    st.found = 1'b1;
                    st.pos   = idx[4:0];
                    pas_remove(idx);
                    note_event(KIND_CLOSE, hit);
                end
            end
            OP_FIND_AP, OP_FIND_AS, OP_FIND_PP, OP_FIND_PS: begin
                case (op)
                    OP_FIND_AP: idx = act_by_peer(peer);
                    OP_FIND_AS: idx = act_by_sock(sock);
                    OP_FIND_PP: idx = pas_by_peer(peer);
                    default:    idx = pas_by_sock(sock);
                endcase
                if (idx >= 0) begin
                    hit      = (op == OP_FIND_AP || op == OP_FIND_AS) ? act_tab[idx]
                                                                      : pas_tab[idx];
                    st.found = 1'b1;
                    st.pos   = idx[4:0];
                    st.peer  = hit.peer;
                    st.sock  = hit.ok ? hit.sock : 16'd0;
                end
            end
            default: ;
        endcase
        st.kind = KIND_STATUS;
        request_events = {request_events, st};
        foreach (request_events[k]) begin
            request_events[k].act_n = act_n[3:0];
            request_events[k].pas_n = pas_n[5:0];
            request_events[k].last  = (k == request_events.size() - 1);
            expected_results = {expected_results, request_events[k]};
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_kind, o_target_peer, o_target_socket, o_found, o_position,
                    o_active_count, o_passive_count, o_last};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d peer %h sock %h", got.kind,
                             got.peer, got.sock);
            end else begin
                want = expected_results.pop_front();
                if (got.kind != want.kind || got.peer != want.peer || got.sock != want.sock
                    || got.found != want.found || got.pos != want.pos
                    || got.act_n != want.act_n || got.pas_n != want.pas_n
                    || got.last != want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp: kind %0d peer %h sock %h found %0d pos %0d act %0d pas %0d last %0d",
                                 want.kind, want.peer, want.sock, want.found, want.pos,
                                 want.act_n, want.pas_n, want.last);
                        $display("         got: kind %0d peer %h sock %h found %0d pos %0d act %0d pas %0d last %0d",
                                 got.kind, got.peer, got.sock, got.found, got.pos,
                                 got.act_n, got.pas_n, got.last);
                    end
                end
            end
        end
    end

    // one request, with an optional idle gap before it
    task automatic send_request(logic [3:0] op, logic [15:0] peer, logic [15:0] sock,
                                logic has);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_peer_id       <= peer;
        i_socket_handle <= sock;
        i_has_socket    <= has;
        do @(posedge i_clk); while (o_in_stall);
        predict_request(op, peer, sock, has);
    endtask

    // stop sending and wait for every result plus settling time
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ACT_CAP: act_cap = data[3:0];
            CFG_PAS_CAP: pas_cap = data[5:0];
            CFG_SEED:    evict_lfsr = (data == 16'd0) ? 16'd1 : data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // every opcode, field extremes, found and not-found paths
    task automatic test_directed_ops();
        send_request(OP_ADD_ACT, 16'h0000, 16'h0000, 1'b1);
        send_request(OP_ADD_ACT, 16'hFFFF, 16'hFFFF, 1'b0);
        send_request(OP_ADD_PAS, 16'h1234, 16'hFFFF, 1'b1);
        send_request(OP_FIND_AP, 16'hFFFF, 16'h0000, 1'b0);
        send_request(OP_FIND_AS, 16'h0000, 16'h0000, 1'b0);
        send_request(OP_FIND_AS, 16'h0000, 16'hFFFF, 1'b0);
        send_request(OP_FIND_PP, 16'h1234, 16'h0000, 1'b0);
        send_request(OP_FIND_PS, 16'h0000, 16'hFFFF, 1'b0);
        send_request(OP_ADD_PAS, 16'h0000, 16'h5555, 1'b1);
        send_request(OP_ADD_PAS, 16'h1234, 16'h0001, 1'b0);
        send_request(OP_ADD_ACT, 16'h1234, 16'hAAAA, 1'b1);
        send_request(OP_ADD_ACT, 16'h0000, 16'h0000, 1'b1);
        send_request(OP_DROP_AS, 16'h0000, 16'hFFFF, 1'b0);
        send_request(OP_DROP_AS, 16'h0000, 16'h0000, 1'b0);
        send_request(OP_DROP_AP, 16'hFFFF, 16'h0000, 1'b0);
        send_request(OP_ADD_PAS, 16'h00AA, 16'h7777, 1'b1);
        send_request(OP_DROP_PS, 16'h0000, 16'h7777, 1'b0);
        send_request(OP_DROP_PS, 16'h0000, 16'h7777, 1'b0);
        send_request(OP_UNKNOWN, 16'hFFFF, 16'hFFFF, 1'b1);
        drain();
    endtask

    // single-entry tables: notice then close in one request
    task automatic test_tiny_capacity();
        cfg_write(CFG_ACT_CAP, 16'd1);
        cfg_write(CFG_PAS_CAP, 16'd1);
        cfg_write(CFG_SEED, 16'hFFFF);
        send_request(OP_ADD_ACT, 16'h0101, 16'h0A0A, 1'b1);
        send_request(OP_ADD_ACT, 16'h0202, 16'h0B0B, 1'b1);
        send_request(OP_ADD_ACT, 16'h0303, 16'h0C0C, 1'b0);
        send_request(OP_ADD_ACT, 16'h0404, 16'h0D0D, 1'b1);
        send_request(OP_ADD_PAS, 16'h0505, 16'h0E0E, 1'b1);
        drain();
    endtask

    // random traffic over a small peer and socket pool
    task automatic test_random_traffic(int count);
        logic [3:0]  op;
        logic [15:0] peer;
        logic [15:0] sock;
        int          sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 25)      op = OP_ADD_ACT;
            else if (sel < 45) op = OP_ADD_PAS;
            else if (sel < 65) op = 4'($urandom_range(OP_DROP_AP, OP_DROP_PS));
            else if (sel < 92) op = 4'($urandom_range(OP_FIND_AP, OP_FIND_PS));
            else               op = 4'($urandom_range(OP_FIND_PS + 1, OP_UNKNOWN));
            peer = ($urandom_range(99) < 80) ? 16'($urandom_range(0, 47)) : 16'($urandom);
            sock = ($urandom_range(99) < 75) ? 16'($urandom_range(0, 15)) : 16'($urandom);
            send_request(op, peer, sock, $urandom_range(99) < 75);
        end
        drain();
    endtask

    // settings sweep across idling phases
    task automatic test_config_sweep();
        send_idle_pct = 53;
        stall_pct     = 0;
        cfg_write(CFG_ACT_CAP, 16'd8);
        cfg_write(CFG_PAS_CAP, 16'd32);
        cfg_write(CFG_SEED, 16'hACE1);
        test_random_traffic(25);
        send_idle_pct = 0;
        stall_pct     = 53;
        cfg_write(CFG_ACT_CAP, 16'd0);
        cfg_write(CFG_PAS_CAP, 16'd0);
        cfg_write(CFG_SEED, 16'd0);
        test_random_traffic(15);
        send_idle_pct = 31;
        stall_pct     = 31;
        cfg_write(CFG_ACT_CAP, 16'd15);
        cfg_write(CFG_PAS_CAP, 16'd63);
        cfg_write(CFG_SEED, 16'h5A5A);
        test_random_traffic(35);
        cfg_write(CFG_ACT_CAP, 16'd3);
        cfg_write(CFG_PAS_CAP, 16'd4);
        cfg_write(CFG_SEED, 16'h8001);
        test_random_traffic(20);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_opcode        = '0;
        i_peer_id       = '0;
        i_socket_handle = '0;
        i_has_socket    = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        act_n           = 0;
        pas_n           = 0;
        act_cap         = 5;
        pas_cap         = 30;
        evict_lfsr      = 16'd1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_ops();
        test_tiny_capacity();
        test_random_traffic(10);
        test_config_sweep();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/pvt_pkg.sv
rtl/core/pvt_mod.sv
rtl/core/peer_view_table.sv
rtl/core/pvt_checker.sv
sim/tb_peer_view_table.sv
